>>> rtl/ntes_pkg.sv
// Shared types and constants for the note tone envelope synthesiser.
// Holds field widths, register codes, reset values and the divider request/response structs.
// No dependencies.
`timescale 1ns / 1ps

package ntes_pkg;

	// Field widths
	localparam int KIND_W   = 1;
	localparam int PITCH_W  = 3;
	localparam int DUR_W    = 5;
	localparam int WNS_W    = 18;
	localparam int AMP_W    = 15;
	localparam int SMP_W    = 16;
	localparam int CNT_W    = 22;
	localparam int NUM_W    = CNT_W + AMP_W;
	localparam int QUOT_W   = 16;
	localparam int CFG_IDX_W = 2;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 2 * SMP_W;

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_LOAD = 1'b0;
	localparam logic [KIND_W-1:0] KIND_TICK = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WHOLE_NOTE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK          = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK_FLOOR  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DECLINE_FLOOR = 2'd3;

	// Register reset values
	localparam logic [WNS_W-1:0] WNS_RESET  = 18'd88200;
	localparam logic [AMP_W-1:0] PEAK_RESET = 15'd32760;
	localparam logic [AMP_W-1:0] AFL_RESET  = 15'd0;
	localparam logic [AMP_W-1:0] DFL_RESET  = 15'd0;

	// Divide by ten: floor(n * DIV10_MUL / 2^DIV10_SHIFT) is exact for n below 2^22
	localparam int DIV10_MUL_W = 20;
	localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 20'd838861;
	localparam int DIV10_SHIFT = 23;

	// Note frequencies in millihertz: C4 D4 E4 F4 G4 A4 B4, then A4 as default
	localparam logic [19:0] PITCH_MHZ [8] = '{
		20'd261626, 20'd293665, 20'd329628, 20'd349228,
		20'd391995, 20'd440000, 20'd493883, 20'd440000
	};

	// Sine table build constants (Q30)
	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] SINE_AMP    = 64'd32767;

	// Divider request and response
	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [CNT_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
	} div_rsp_t;

endpackage

>>> rtl/ntes_sine_rom.sv
// Sine look-up ROM, Q1.15, one full wave, registered read.
// Contents are built at elaboration from a quarter-wave Taylor series; uses ntes_pkg.
`timescale 1ns / 1ps

module ntes_sine_rom #(
	parameter int DEPTH = 1024
) (
	input  logic                           clk,
	input  logic                           rd_en,
	input  logic [$clog2(DEPTH)-1:0]       addr,
	output logic signed [ntes_pkg::SMP_W-1:0] data
);

	typedef logic signed [ntes_pkg::SMP_W-1:0] rom_t [DEPTH];

	// round(32767 * sin(2*pi*k/DEPTH)) with Q30 fixed-point series
	function automatic logic signed [ntes_pkg::SMP_W-1:0] sine_entry(input int k);
		logic [63:0] a;
		logic [1:0]  quad;
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] s;
		logic [63:0] v;
		a    = (64'(k) << 32) / DEPTH;
		quad = a[31:30];
		r    = a & (ntes_pkg::Q30_ONE - 64'd1);
		if (quad[0]) begin
			r = ntes_pkg::Q30_ONE - r;
		end
		x    = (r * ntes_pkg::HALF_PI_Q30) >> 30;
		x2   = (x * x) >> 30;
		term = x;
		pos  = x;
		neg  = 64'd0;
		term = ((term * x2) >> 30) / 64'd6;   neg = neg + term;
		term = ((term * x2) >> 30) / 64'd20;  pos = pos + term;
		term = ((term * x2) >> 30) / 64'd42;  neg = neg + term;
		term = ((term * x2) >> 30) / 64'd72;  pos = pos + term;
		term = ((term * x2) >> 30) / 64'd110; neg = neg + term;
		term = ((term * x2) >> 30) / 64'd156; pos = pos + term;
		term = ((term * x2) >> 30) / 64'd210; neg = neg + term;
		term = ((term * x2) >> 30) / 64'd272; pos = pos + term;
		term = ((term * x2) >> 30) / 64'd342; neg = neg + term;
		term = ((term * x2) >> 30) / 64'd420; pos = pos + term;
		s = (neg > pos) ? 64'd0 : pos - neg;
		v = (s * ntes_pkg::SINE_AMP + (ntes_pkg::Q30_ONE >> 1)) >> 30;
		if (v > ntes_pkg::SINE_AMP) begin
			v = ntes_pkg::SINE_AMP;
		end
		sine_entry = quad[1] ? -ntes_pkg::SMP_W'(v) : ntes_pkg::SMP_W'(v);
	endfunction

	function automatic rom_t build_rom();
		rom_t t;
		for (int k = 0; k < DEPTH; k++) begin
			t[k] = sine_entry(k);
		end
		build_rom = t;
	endfunction

	localparam rom_t SINE_LUT = build_rom();

	// Registered read; hold the last word while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			data <= SINE_LUT[addr];
		end
	end

endmodule

>>> rtl/ntes_div.sv
// Iterative restoring divider for the envelope slope, one quotient bit per cycle.
// Expects num / den below 2^QUOT_W; uses ntes_pkg request/response structs.
`timescale 1ns / 1ps

module ntes_div (
	input  logic               clk,
	input  logic               arst_n,
	input  ntes_pkg::div_req_t req,
	output ntes_pkg::div_rsp_t rsp
);

	localparam int QW    = ntes_pkg::QUOT_W;
	localparam int DW    = ntes_pkg::CNT_W;
	localparam int STEPW = $clog2(QW + 1);

	logic             busy_q;
	logic             done_q;
	logic [STEPW-1:0] step_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    den_q;
	logic [QW-1:0]    sh_q;

	logic [DW:0]      trial;
	logic             fits;
	logic [DW:0]      diff;

	// Trial subtract of the divisor from the shifted remainder
	assign trial = {rem_q, sh_q[QW-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEPW'(QW);
			end else if (busy_q) begin
				step_q <= step_q - STEPW'(1);
				if (step_q == STEPW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Load the operands, then shift quotient bits in as dividend bits leave
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= DW'(req.num[ntes_pkg::NUM_W-1:QW]);
			sh_q  <= req.num[QW-1:0];
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
			sh_q  <= {sh_q[QW-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = sh_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done && !busy_q)
		else $error("divider done held or busy after completion");

endmodule

>>> rtl/note_tone_envelope_synth_unit.sv
// Top level of the note tone synthesiser: handshake, note state, envelope and mixing.
// Instantiates ntes_sine_rom and ntes_div; uses ntes_pkg.
`timescale 1ns / 1ps

// A load item (tuser 0) latches pitch and duration; it gives no result. A tick (tuser 1)
// gives one result: during a note it passes ST_ENV, the 16-step envelope divider in
// ST_DIV, ST_MIX and ST_OUT, and an idle tick goes straight to ST_OUT. One item is worked
// on at a time; the next item is taken once the result is in the output register, even if
// that result has not yet been taken. The sine table is a registered ROM read once per
// accepted item. Configuration writes are always ready and take effect at once.
module note_tone_envelope_synth_unit #(
	parameter int SINE_TABLE_DEPTH = 1024,
	parameter int SAMPLE_RATE      = 44100,
	parameter int PHASE_BITS       = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Input items
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [ntes_pkg::IN_DATA_W-1:0]       s_tdata,  // [2:0] pitch_code, [7:3] duration_sixteenths
	input  logic                                 s_tuser,  // [0] kind
	// Result items
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [ntes_pkg::OUT_DATA_W-1:0]      m_tdata,  // [15:0] left_sample, [31:16] right_sample
	output logic                                 m_tuser,  // [0] sample_valid
	output logic                                 m_tlast,  // note_last
	// Configuration writes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ntes_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ntes_pkg::WNS_W-1:0]           cfg_data
);

	localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
	localparam int CW     = ntes_pkg::CNT_W;
	localparam int AW     = ntes_pkg::AMP_W;
	localparam int SW     = ntes_pkg::SMP_W;
	localparam int LPW    = ntes_pkg::DUR_W + ntes_pkg::WNS_W;
	localparam int APW    = CW + ntes_pkg::DIV10_MUL_W;
	localparam logic [63:0] PitchDen = 64'(SAMPLE_RATE) * 64'd1000;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_ATTACK = 6'b000010,
		ST_ENV    = 6'b000100,
		ST_DIV    = 6'b001000,
		ST_MIX    = 6'b010000,
		ST_OUT    = 6'b100000
	} state_t;

	// Phase step per note: round(f * 2^PHASE_BITS / SAMPLE_RATE)
	function automatic logic [63:0] pitch_step(input int p);
		pitch_step = ((64'(ntes_pkg::PITCH_MHZ[p]) << PHASE_BITS) + PitchDen / 2) / PitchDen;
	endfunction

	localparam logic [PHASE_BITS-1:0] PITCH_STEP [8] = '{
		PHASE_BITS'(pitch_step(0)), PHASE_BITS'(pitch_step(1)),
		PHASE_BITS'(pitch_step(2)), PHASE_BITS'(pitch_step(3)),
		PHASE_BITS'(pitch_step(4)), PHASE_BITS'(pitch_step(5)),
		PHASE_BITS'(pitch_step(6)), PHASE_BITS'(pitch_step(7))
	};

	state_t state_q;

	// Configuration registers
	logic [ntes_pkg::WNS_W-1:0] wns_q;
	logic [AW-1:0]              peak_q;
	logic [AW-1:0]              afl_q;
	logic [AW-1:0]              dfl_q;

	// Note state
	logic [PHASE_BITS-1:0] phase_acc_q;
	logic [PHASE_BITS-1:0] phase_step_q;
	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         note_len_q;
	logic [CW-1:0]         att_len_q;
	logic                  playing_q;

	// Per-tick working registers
	logic [AW-1:0]         base_q;
	logic                  sub_q;
	logic signed [31:0]    mix_q;

	// Output register
	logic                  out_valid_q;
	logic signed [SW-1:0]  out_smp_q;
	logic                  out_sv_q;
	logic                  out_last_q;

	logic                  in_acc;
	logic                  out_free;
	logic [ntes_pkg::PITCH_W-1:0] in_pitch;
	logic [ntes_pkg::DUR_W-1:0]   in_dur;
	logic [LPW-1:0]        len_prod;
	logic [APW-1:0]        att_prod;
	logic [PHASE_BITS+IDX_W-1:0] idx_prod;
	logic [IDX_W-1:0]      rom_addr;
	logic signed [SW-1:0]  sine_val;

	logic                  in_att;
	logic signed [AW:0]    d_att;
	logic signed [AW:0]    d_dec;
	logic [AW-1:0]         mag;
	logic [CW-1:0]         mcand;
	logic [ntes_pkg::NUM_W-1:0] num_prod;
	ntes_pkg::div_req_t    div_req;
	ntes_pkg::div_rsp_t    div_rsp;

	logic signed [AW+1:0]  env_full;
	logic signed [SW-1:0]  env_val;
	logic signed [31:0]    mix_prod;
	logic signed [31:0]    mix_rnd;
	logic signed [SW-1:0]  smp;
	logic [CW:0]           cnt_next;
	logic                  last;

	assign in_acc   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || m_tready;
	assign cfg_ready = 1'b1;

	assign in_pitch = s_tdata[ntes_pkg::PITCH_W-1:0];
	assign in_dur   = s_tdata[ntes_pkg::PITCH_W +: ntes_pkg::DUR_W];

	// Note length and attack length
	assign len_prod = LPW'(in_dur) * LPW'(wns_q);
	assign att_prod = APW'(note_len_q) * APW'(ntes_pkg::DIV10_MUL);

	// Sine table index from the phase held before the step
	assign idx_prod = (PHASE_BITS+IDX_W)'(phase_acc_q) * (PHASE_BITS+IDX_W)'(SINE_TABLE_DEPTH);
	assign rom_addr = idx_prod[PHASE_BITS +: IDX_W];

	ntes_sine_rom #(
		.DEPTH (SINE_TABLE_DEPTH)
	) u_rom (
		.clk   (clk),
		.rd_en (in_acc),
		.addr  (rom_addr),
		.data  (sine_val)
	);

	// Envelope slope: numerator magnitude, divisor and direction for this sample
	assign in_att = cnt_q < att_len_q;
	assign d_att  = $signed({1'b0, peak_q}) - $signed({1'b0, afl_q});
	assign d_dec  = $signed({1'b0, peak_q}) - $signed({1'b0, dfl_q});
	always_comb begin
		if (in_att) begin
			mag   = d_att[AW] ? AW'(-d_att) : d_att[AW-1:0];
			mcand = cnt_q;
		end else begin
			mag   = d_dec[AW] ? AW'(-d_dec) : d_dec[AW-1:0];
			mcand = cnt_q - att_len_q;
		end
	end
	assign num_prod = ntes_pkg::NUM_W'(mcand) * ntes_pkg::NUM_W'(mag);

	assign div_req.start = (state_q == ST_ENV);
	assign div_req.num   = num_prod;
	assign div_req.den   = in_att ? att_len_q : note_len_q - att_len_q;

	ntes_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Envelope value and its product with the sine word
	assign env_full = sub_q ? $signed({2'b00, base_q}) - $signed({1'b0, div_rsp.quot})
	                        : $signed({2'b00, base_q}) + $signed({1'b0, div_rsp.quot});
	assign env_val  = SW'(env_full);
	assign mix_prod = env_val * sine_val;

	// Truncate toward zero on the divide by 2^15
	assign mix_rnd  = mix_q[31] ? mix_q + 32'sd32767 : mix_q;
	assign smp      = SW'(mix_rnd >>> 15);
	assign cnt_next = {1'b0, cnt_q} + (CW+1)'(1);
	assign last     = cnt_next >= {1'b0, note_len_q};

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wns_q  <= ntes_pkg::WNS_RESET;
			peak_q <= ntes_pkg::PEAK_RESET;
			afl_q  <= ntes_pkg::AFL_RESET;
			dfl_q  <= ntes_pkg::DFL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ntes_pkg::REG_WHOLE_NOTE:    wns_q  <= cfg_data;
				ntes_pkg::REG_PEAK:          peak_q <= cfg_data[AW-1:0];
				ntes_pkg::REG_ATTACK_FLOOR:  afl_q  <= cfg_data[AW-1:0];
				ntes_pkg::REG_DECLINE_FLOOR: dfl_q  <= cfg_data[AW-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer and note state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_acc_q  <= '0;
			phase_step_q <= '0;
			cnt_q        <= '0;
			note_len_q   <= '0;
			att_len_q    <= '0;
			playing_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_tuser == ntes_pkg::KIND_LOAD) begin
							phase_acc_q  <= '0;
							cnt_q        <= '0;
							phase_step_q <= PITCH_STEP[in_pitch];
							note_len_q   <= CW'(len_prod >> 4);
							playing_q    <= 1'b0;
							state_q      <= ST_ATTACK;
						end else if (playing_q) begin
							state_q <= ST_ENV;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_ATTACK: begin
					att_len_q <= CW'(att_prod >> ntes_pkg::DIV10_SHIFT);
					playing_q <= (note_len_q != '0);
					state_q   <= ST_IDLE;
				end
				ST_ENV: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_MIX;
					end
				end
				ST_MIX: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						if (playing_q) begin
							phase_acc_q <= phase_acc_q + phase_step_q;
							cnt_q       <= cnt_next[CW-1:0];
							if (last) begin
								playing_q <= 1'b0;
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the envelope base and direction, then the mixed product
	always_ff @(posedge clk) begin
		if (state_q == ST_ENV) begin
			base_q <= in_att ? afl_q : peak_q;
			sub_q  <= in_att ? d_att[AW] : !d_dec[AW];
		end
		if (state_q == ST_MIX) begin
			mix_q <= mix_prod;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_smp_q   <= '0;
			out_sv_q    <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
				out_smp_q   <= playing_q ? smp : '0;
				out_sv_q    <= playing_q;
				out_last_q  <= playing_q && last;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_smp_q, out_smp_q};
	assign m_tuser  = out_sv_q;
	assign m_tlast  = out_last_q;

	a_lr_equal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[SW-1:0] == m_tdata[2*SW-1:SW])
		else $error("left and right samples differ");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0 && !m_tlast)
		else $error("idle tick result is not zero");

	a_note_shape: assert property (@(posedge clk) disable iff (!arst_n)
		playing_q |-> note_len_q != '0 && att_len_q < note_len_q)
		else $error("playing with an empty note or oversized attack");

	a_env_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MIX |-> !env_full[AW+1] && !env_full[AW])
		else $error("envelope out of range");

endmodule
